// ===== hw/rtl/sls_pkg.sv =====
// shared types, codes and constants of the staggered lamp scheduler
package sls_pkg;

	// minutes in a day and the time range used by the lamp compares
	localparam int TIME_W = 11;
	localparam int CALC_W = 14;
	localparam logic signed [CALC_W-1:0] DAY_MIN = 14'sd1440;

	// override hold time and lamp count
	localparam logic [31:0] HOLD_MS = 32'd1800000;
	localparam int LAMP_COUNT = 3;
	localparam int LAMP_W = 3;
	localparam int LAMP_OUT = (LAMP_COUNT < LAMP_W) ? LAMP_COUNT : LAMP_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LAMP_INTERVAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MORNING_HOUR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MORNING_MINUTE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENING_HOUR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EVENING_MINUTE = 3'd4;

	// override mode codes as reported on the result
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_ON   = 2'd1;
	localparam logic [1:0] MODE_OFF  = 2'd2;

	typedef struct packed {
		logic [7:0] lamp_interval;
		logic [4:0] morning_hour;
		logic [5:0] morning_minute;
		logic [4:0] evening_hour;
		logic [5:0] evening_minute;
	} sls_cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       beep;
	} ovr_res_t;

endpackage

// ===== hw/rtl/sls_ovr.sv =====
// manual override state machine with hold deadline and end-of-override beep
module sls_ovr (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              cmd,
	input  logic [31:0]       now_ms,
	input  logic              is_day,
	output sls_pkg::ovr_res_t res
);
	import sls_pkg::*;

	typedef enum logic [2:0] {
		ST_NONE = 3'b001,
		ST_ON   = 3'b010,
		ST_OFF  = 3'b100
	} ovr_state_t;

	ovr_state_t  state_q, state_d, first;
	logic [31:0] deadline_q, deadline_d;
	logic        beep_d;

	assign first = is_day ? ST_OFF : ST_ON;

	always_comb begin
		state_d    = state_q;
		deadline_d = deadline_q;
		beep_d     = 1'b0;
		// press steps the cycle and restarts the hold
		if (cmd) begin
			if (state_q == ST_NONE)
				state_d = first;
			else if (state_q == first)
				state_d = (first == ST_OFF) ? ST_ON : ST_OFF;
			else
				state_d = ST_NONE;
			deadline_d = now_ms + HOLD_MS;
		end
		// lapse, unsigned compare
		if (state_d != ST_NONE && now_ms >= deadline_d)
			state_d = ST_NONE;
		if (state_d == ST_NONE && deadline_d != '0) begin
			deadline_d = '0;
			beep_d     = 1'b1;
		end
	end

	always_comb begin
		unique case (state_d)
			ST_ON:   res.mode = MODE_ON;
			ST_OFF:  res.mode = MODE_OFF;
			ST_NONE: res.mode = MODE_NONE;
			default: res.mode = MODE_NONE;
		endcase
		res.beep = beep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_NONE;
			deadline_q <= '0;
		end else if (fire) begin
			state_q    <= state_d;
			deadline_q <= deadline_d;
		end
	end

endmodule

// ===== hw/rtl/sls_sched.sv =====
// per-lamp on/off window compares with day wrap, then the override and is_day select
module sls_sched (
	input  sls_pkg::sls_cfg_t cfg,
	input  logic [4:0]        now_hour,
	input  logic [5:0]        now_minute,
	input  logic              is_day,
	input  logic [1:0]        mode,
	output logic [2:0]        lamp_on
);
	import sls_pkg::*;

	logic [TIME_W-1:0]        now_t, morn_t, eve_t;
	logic signed [CALC_W-1:0] now_v, morn_v, eve_v;
	logic [LAMP_W-1:0]        sched_mask;

	assign now_t  = TIME_W'(now_hour) * TIME_W'(60) + TIME_W'(now_minute);
	assign morn_t = TIME_W'(cfg.morning_hour) * TIME_W'(60) + TIME_W'(cfg.morning_minute);
	assign eve_t  = TIME_W'(cfg.evening_hour) * TIME_W'(60) + TIME_W'(cfg.evening_minute);
	assign now_v  = $signed(CALC_W'(now_t));
	assign morn_v = $signed(CALC_W'(morn_t));
	assign eve_v  = $signed(CALC_W'(eve_t));

	always_comb begin
		logic signed [CALC_W-1:0] t_on, t_off;
		logic                     lit;
		sched_mask = '0;
		for (int i = 0; i < LAMP_OUT; i++) begin
			t_on  = morn_v + $signed(CALC_W'(cfg.lamp_interval) * CALC_W'(i));
			t_off = eve_v - $signed(CALC_W'(cfg.lamp_interval) * CALC_W'(LAMP_COUNT - 1 - i));
			// switch-on side
			if (now_v >= morn_v)
				lit = (now_v >= t_on);
			else if (t_on >= DAY_MIN)
				lit = (now_v >= t_on - DAY_MIN);
			else
				lit = 1'b1;
			// switch-off side
			if (now_v < eve_v) begin
				if (now_v >= t_off)
					lit = 1'b0;
			end else if (t_off < 0) begin
				if (now_v >= t_off + DAY_MIN)
					lit = 1'b0;
			end
			sched_mask[i] = lit;
		end
	end

	always_comb begin
		priority if (mode == MODE_OFF || !is_day)
			lamp_on = '0;
		else if (mode == MODE_ON)
			lamp_on = '1;
		else
			lamp_on = sched_mask;
	end

endmodule

// ===== hw/rtl/staggered_lamp_scheduler_top.sv =====
// top level of the staggered lamp scheduler
//
// usage
//  - input channel (in_valid / in_stall) carries one transaction per tick or
//    button press: cmd, now_ms, now_hour, now_minute, is_day
//  - output channel (out_valid / out_stall) returns exactly one transaction
//    per input transaction: lamp_on, beep, override_mode
//  - an accepted input passes from the input register through one pass of
//    override and lamp logic into the result register when that register
//    is empty or being drained
//  - throughput: one transaction per cycle while the output is not stalled,
//    the pass from the input register to the result register being combinational
//  - a stalled result holds in the result register; the input register keeps
//    the next transaction, and in_stall rises only while both are full
//  - configuration: cfg_wr_en writes cfg_data into register cfg_index
//    (0 interval, 1..2 morning hour/minute, 3..4 evening hour/minute);
//    other indexes are ignored; write only while no transaction is in flight
//  - reset (arst_n low) empties both registers, clears the override and its
//    deadline and loads the default schedule 08:00 to 20:00, 30 min apart
module staggered_lamp_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [sls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [31:0]                   now_ms,
	input  logic [4:0]                    now_hour,
	input  logic [5:0]                    now_minute,
	input  logic                          is_day,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    lamp_on,
	output logic                          beep,
	output logic [1:0]                    override_mode
);
	import sls_pkg::*;

	sls_cfg_t    cfg_q;

	// input register
	logic        valid_s1;
	logic        cmd_s1;
	logic [31:0] now_ms_s1;
	logic [4:0]  now_hour_s1;
	logic [5:0]  now_minute_s1;
	logic        is_day_s1;

	// result register
	logic        valid_s2;
	logic [2:0]  lamp_on_s2;
	logic        beep_s2;
	logic [1:0]  mode_s2;

	logic        advance, fire;
	ovr_res_t    ovr_res;
	logic [2:0]  lamp_d;

	// result register can take a new transaction when empty or being drained
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lamp_interval  <= 8'd30;
			cfg_q.morning_hour   <= 5'd8;
			cfg_q.morning_minute <= 6'd0;
			cfg_q.evening_hour   <= 5'd20;
			cfg_q.evening_minute <= 6'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LAMP_INTERVAL:  cfg_q.lamp_interval  <= cfg_data;
				REG_MORNING_HOUR:   cfg_q.morning_hour   <= cfg_data[4:0];
				REG_MORNING_MINUTE: cfg_q.morning_minute <= cfg_data[5:0];
				REG_EVENING_HOUR:   cfg_q.evening_hour   <= cfg_data[4:0];
				REG_EVENING_MINUTE: cfg_q.evening_minute <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1        <= cmd;
			now_ms_s1     <= now_ms;
			now_hour_s1   <= now_hour;
			now_minute_s1 <= now_minute;
			is_day_s1     <= is_day;
		end
	end

	// override state updates only when the transaction moves on
	sls_ovr u_ovr (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.now_ms (now_ms_s1),
		.is_day (is_day_s1),
		.res    (ovr_res)
	);

	// lamp mask uses the override after this transaction
	sls_sched u_sched (
		.cfg        (cfg_q),
		.now_hour   (now_hour_s1),
		.now_minute (now_minute_s1),
		.is_day     (is_day_s1),
		.mode       (ovr_res.mode),
		.lamp_on    (lamp_d)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			lamp_on_s2 <= lamp_d;
			beep_s2    <= ovr_res.beep;
			mode_s2    <= ovr_res.mode;
		end
	end

	assign out_valid     = valid_s2;
	assign lamp_on       = lamp_on_s2;
	assign beep          = beep_s2;
	assign override_mode = mode_s2;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench of the staggered lamp scheduler
`timescale 1ns / 100ps

module tb;
	import sls_pkg::*;

	// command codes of the input transaction
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	typedef struct {
		logic        cmd;
		logic [31:0] now_ms;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic        is_day;
	} lamp_req_t;

	typedef struct {
		logic [2:0] lamps;
		logic       beep;
		logic [1:0] mode;
	} lamp_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic [31:0] now_ms = '0;
	logic [4:0]  now_hour = '0;
	logic [5:0]  now_minute = '0;
	logic        is_day = 1'b0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] lamp_on;
	logic       beep;
	logic [1:0] override_mode;

	// stimulus waiting to be sent and results still owed by the block
	lamp_req_t pending_reqs[$];
	lamp_res_t expected_lamp_results[$];
	lamp_req_t sent_req;

	// shadow of the block: schedule registers and override state
	sls_cfg_t    sched_cfg;
	logic [1:0]  ovr_mode;
	logic [31:0] ovr_deadline;

	// idle rates in percent, per side
	int unsigned send_idle_pct = 18;
	int unsigned recv_stall_pct = 18;

	logic [31:0] ms_clock = '0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_presses = 0;
	int unsigned n_beeps = 0;
	int unsigned n_settings = 1;
	int unsigned n_errors = 0;

	staggered_lamp_scheduler_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.now_ms       (now_ms),
		.now_hour     (now_hour),
		.now_minute   (now_minute),
		.is_day       (is_day),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.lamp_on      (lamp_on),
		.beep         (beep),
		.override_mode(override_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// steps the override and works out the lamp states for one transaction
	function automatic lamp_res_t next_lamp_result(lamp_req_t rq);
		lamp_res_t  res;
		logic [1:0] first;
		int         now_t, morn, eve, gap, t_on, t_off;
		bit         lit;
		res.beep = 1'b0;
		res.lamps = '0;
		// a press walks the cycle; day presses go to forced off first
		if (rq.cmd == CMD_PRESS) begin
			first = rq.is_day ? MODE_OFF : MODE_ON;
			if (ovr_mode == MODE_NONE)
				ovr_mode = first;
			else if (ovr_mode == first)
				ovr_mode = (ovr_mode == MODE_OFF) ? MODE_ON : MODE_OFF;
			else
				ovr_mode = MODE_NONE;
			ovr_deadline = rq.now_ms + HOLD_MS;
		end
		// lapse is a plain unsigned compare, wrapped deadlines expire at once
		if (ovr_mode != MODE_NONE && rq.now_ms >= ovr_deadline)
			ovr_mode = MODE_NONE;
		if (ovr_mode == MODE_NONE && ovr_deadline != 0) begin
			ovr_deadline = '0;
			res.beep = 1'b1;
		end
		res.mode = ovr_mode;
		if (ovr_mode == MODE_OFF || !rq.is_day)
			return res;
		if (ovr_mode == MODE_ON) begin
			res.lamps = '1;
			return res;
		end
		now_t = rq.now_hour * 60 + rq.now_minute;
		morn = sched_cfg.morning_hour * 60 + sched_cfg.morning_minute;
		eve = sched_cfg.evening_hour * 60 + sched_cfg.evening_minute;
		gap = sched_cfg.lamp_interval;
		for (int i = 0; i < LAMP_COUNT; i++) begin
			t_on = morn + gap * i;
			t_off = eve - gap * (LAMP_COUNT - 1 - i);
			if (now_t >= morn)
				lit = now_t >= t_on;
			else if (t_on >= 1440)
				lit = now_t >= t_on - 1440;
			else
				lit = 1'b1;
			if (now_t < eve) begin
				if (now_t >= t_off)
					lit = 1'b0;
			end else if (t_off < 0) begin
				if (now_t >= t_off + 1440)
					lit = 1'b0;
			end
			if (lit && i < LAMP_W)
				res.lamps[i] = 1'b1;
		end
		return res;
	endfunction

	// driver: presents queued transactions, holds them while stalled
	always @(posedge clk or negedge arst_n) begin : drive_requests
		lamp_req_t nxt;
		logic      nxt_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nxt = sent_req;
			nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				// the block took it, so the shadow advances now
				expected_lamp_results.push_back(next_lamp_result(sent_req));
				n_sent++;
				if (sent_req.cmd == CMD_PRESS)
					n_presses++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_reqs.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				nxt_valid = 1'b1;
			end
			sent_req = nxt;
			in_valid <= nxt_valid;
			cmd <= nxt.cmd;
			now_ms <= nxt.now_ms;
			now_hour <= nxt.now_hour;
			now_minute <= nxt.now_minute;
			is_day <= nxt.is_day;
		end
	end

	// monitor: checks each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		lamp_res_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_lamp_results.size() == 0) begin
					$display("%0t unexpected result: lamp_on %0h beep %0b mode %0d",
						$time, lamp_on, beep, override_mode);
					n_errors++;
				end else begin
					exp_res = expected_lamp_results.pop_front();
					n_checked++;
					if (beep)
						n_beeps++;
					if (lamp_on !== exp_res.lamps) begin
						$display("%0t lamp_on mismatch: expected %0h actual %0h",
							$time, exp_res.lamps, lamp_on);
						n_errors++;
					end
					if (beep !== exp_res.beep) begin
						$display("%0t beep mismatch: expected %0b actual %0b",
							$time, exp_res.beep, beep);
						n_errors++;
					end
					if (override_mode !== exp_res.mode) begin
						$display("%0t override_mode mismatch: expected %0d actual %0d",
							$time, exp_res.mode, override_mode);
						n_errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic lamp_req_t mk_req(logic c, logic [31:0] ms, logic [4:0] h,
			logic [5:0] m, logic day);
		lamp_req_t rq;
		rq.cmd = c;
		rq.now_ms = ms;
		rq.now_hour = h;
		rq.now_minute = m;
		rq.is_day = day;
		return rq;
	endfunction

	// one register write, mirrored into the shadow copy
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_LAMP_INTERVAL:  sched_cfg.lamp_interval = val;
			REG_MORNING_HOUR:   sched_cfg.morning_hour = val[4:0];
			REG_MORNING_MINUTE: sched_cfg.morning_minute = val[5:0];
			REG_EVENING_HOUR:   sched_cfg.evening_hour = val[4:0];
			REG_EVENING_MINUTE: sched_cfg.evening_minute = val[5:0];
			default: ;
		endcase
	endtask

	// full schedule rewrite plus one write to an unused index
	task automatic load_schedule(logic [7:0] gap, logic [7:0] mh, logic [7:0] mm,
			logic [7:0] eh, logic [7:0] em);
		cfg_write(REG_LAMP_INTERVAL, gap);
		cfg_write(REG_MORNING_HOUR, mh);
		cfg_write(REG_MORNING_MINUTE, mm);
		cfg_write(REG_EVENING_HOUR, eh);
		cfg_write(REG_EVENING_MINUTE, em);
		cfg_write(REG_EVENING_MINUTE + 3'd1 + 3'($urandom_range(2)), 8'($urandom));
		n_settings++;
	endtask

	// sender waits until the block owes nothing
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() != 0 || in_valid ||
			expected_lamp_results.size() != 0);
	endtask

	// mostly in-range times on an advancing clock, some jumps and raw values
	task automatic queue_random(int unsigned n);
		lamp_req_t   rq;
		int unsigned roll;
		for (int unsigned k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < 3)
				ms_clock = $urandom();
			else if (roll < 5)
				ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(3000000));
			else
				ms_clock = ms_clock + 32'($urandom_range(250000));
			rq.cmd = ($urandom_range(99) < 15) ? CMD_PRESS : CMD_TICK;
			rq.now_ms = ms_clock;
			if ($urandom_range(99) < 8) begin
				rq.now_hour = 5'($urandom);
				rq.now_minute = 6'($urandom);
			end else begin
				rq.now_hour = 5'($urandom_range(23));
				rq.now_minute = 6'($urandom_range(59));
			end
			rq.is_day = ($urandom_range(99) < 75);
			pending_reqs.push_back(rq);
		end
	endtask

	task automatic run_phase(int unsigned n);
		queue_random(n / 2);
		drain();
		queue_random(n - n / 2);
		drain();
	endtask

	// shadow reset values match the block defaults
	initial begin
		sched_cfg.lamp_interval = 8'd30;
		sched_cfg.morning_hour = 5'd8;
		sched_cfg.morning_minute = 6'd0;
		sched_cfg.evening_hour = 5'd20;
		sched_cfg.evening_minute = 6'd0;
		ovr_mode = MODE_NONE;
		ovr_deadline = '0;
		sent_req = mk_req(CMD_TICK, '0, '0, '0, 1'b0);
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and night
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd0, 5'd0, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'hFFFF_FFFF, 5'd31, 6'd63, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd500, 5'd12, 6'd0, 1'b0));
		// day press cycle: forced off, forced on, then none with an immediate beep
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd1000, 5'd12, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd2000, 5'd12, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd3000, 5'd12, 6'd0, 1'b1));
		// night press cycle: forced on stays dark at night
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd4000, 5'd12, 6'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd4100, 5'd12, 6'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd4200, 5'd12, 6'd0, 1'b0));
		// hold runs out exactly at the deadline
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd5000, 5'd10, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd5000 + HOLD_MS - 1, 5'd10, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd5000 + HOLD_MS, 5'd10, 6'd0, 1'b1));
		// deadline wrapping past the top lapses at once
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'hFFFF_FF00, 5'd10, 6'd0, 1'b1));
		// deadline wrapping to exactly zero lapses silently
		pending_reqs.push_back(mk_req(CMD_PRESS, 32'd0 - HOLD_MS, 5'd10, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd0 - HOLD_MS + 1, 5'd10, 6'd0, 1'b1));
		// schedule edges around the default morning and evening
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6000, 5'd7, 6'd59, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6001, 5'd8, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6002, 5'd8, 6'd30, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6003, 5'd9, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6004, 5'd19, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6005, 5'd19, 6'd30, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6006, 5'd20, 6'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 32'd6007, 5'd23, 6'd59, 1'b1));
		drain();

		// random phases over several schedules; deadlines carry across them
		ms_clock = 32'd10000;
		run_phase(250);
		load_schedule(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		run_phase(250);
		load_schedule(8'd255, 8'd23, 8'd59, 8'd23, 8'd59);
		run_phase(250);
		// morning after evening, lamps spilling past midnight both ways
		load_schedule(8'd200, 8'd22, 8'd0, 8'd3, 8'd0);
		run_phase(250);
		// raw register values beyond the clock range
		load_schedule(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_phase(250);
		load_schedule(8'($urandom), 8'($urandom_range(23)), 8'($urandom_range(59)),
			8'($urandom_range(23)), 8'($urandom_range(59)));
		run_phase(250);
		// stretch with both sides running flat out
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_schedule(8'd30, 8'd8, 8'd0, 8'd20, 8'd0);
		run_phase(250);

		// let any stray result show up
		repeat (8) @(posedge clk);
		$display("tb: %0d transactions checked (%0d presses, %0d beeps) over %0d schedules",
			n_checked, n_presses, n_beeps, n_settings);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: timeout with %0d results outstanding", expected_lamp_results.size());
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sls_pkg.sv
hw/rtl/sls_ovr.sv
hw/rtl/sls_sched.sv
hw/rtl/staggered_lamp_scheduler_top.sv
dv/tb.sv
